// ----- rtl/met_pkg.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared widths, register indexes and the status bundle from the core.
// ----------------------------------------------------------------------------
package met_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int INDEX_BITS_DEF = 12;
    localparam int ITER_BITS      = 16;
    localparam int SCALE_BITS     = 16;
    localparam int SCALE_FRAC     = 8;
    localparam int SHADE_BITS     = 8;
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ORIGIN_REAL     = 3'd0,
        CFG_ORIGIN_IMAG     = 3'd1,
        CFG_STEP_REAL       = 3'd2,
        CFG_STEP_IMAG       = 3'd3,
        CFG_MAX_ITERATIONS  = 3'd4,
        CFG_INTENSITY_SCALE = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                 done;
        logic                 escaped;
        logic [ITER_BITS-1:0] count;
    } t_status;

endpackage

// ----- rtl/met_core.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time core
// Microcoded sequencer over a saturating add unit and a shared multiplier.
// ----------------------------------------------------------------------------
module met_core #(
    parameter int COORD_BITS = met_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = met_pkg::INDEX_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [INDEX_BITS-1:0]           i_col,
    input  logic [INDEX_BITS-1:0]           i_row,
    input  logic signed [COORD_BITS-1:0]    i_origin_real,
    input  logic signed [COORD_BITS-1:0]    i_origin_imag,
    input  logic signed [COORD_BITS-1:0]    i_step_real,
    input  logic signed [COORD_BITS-1:0]    i_step_imag,
    input  logic [met_pkg::ITER_BITS-1:0]   i_max_iterations,
    output logic                            o_busy,
    output met_pkg::t_status                o_status
);
    import met_pkg::*;

    localparam int FRAC   = COORD_BITS - 4;
    localparam int HALF   = (COORD_BITS + 1) / 2;
    localparam int MW     = 2 * HALF;
    localparam int ACC_W  = 4 * HALF;
    localparam int UPC_W  = 4;
    localparam logic [2:0] PP_LAST = 3'd5;
    localparam logic [UPC_W-1:0] UPC_LOOP = 4'd5;
    localparam logic [UPC_W-1:0] UPC_DONE = 4'd15;
    localparam logic signed [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] FOUR = {2'b01, {(COORD_BITS-2){1'b0}}};

    typedef enum logic [2:0] {
        OP_MUL, OP_ADD, OP_SUB, OP_CLR, OP_TLIM, OP_TESC, OP_FINISH
    } t_op;

    typedef enum logic [3:0] {
        SRC_ZR, SRC_ZI, SRC_SR, SRC_SI, SRC_CROSS, SRC_T, SRC_CR, SRC_CI,
        SRC_ORG_R, SRC_ORG_I, SRC_STEP_R, SRC_STEP_I, SRC_COL, SRC_ROW
    } t_src;

    typedef enum logic [3:0] {
        DST_NONE, DST_T, DST_CR, DST_CI, DST_ZR, DST_ZI, DST_SR, DST_SI, DST_CROSS
    } t_dst;

    typedef struct packed {
        t_op              op;
        t_src             a;
        t_src             b;
        t_dst             dst;
        logic             frac;
        logic             jump;
        logic             inc;
        logic [UPC_W-1:0] target;
    } t_uword;

    function automatic t_uword mk(input t_op op, input t_src a, input t_src b,
                                  input t_dst dst, input logic frac, input logic jump,
                                  input logic inc, input logic [UPC_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.a      = a;
        w.b      = b;
        w.dst    = dst;
        w.frac   = frac;
        w.jump   = jump;
        w.inc    = inc;
        w.target = target;
        return w;
    endfunction

    // Control store: pixel mapping, then the iteration loop.
    function automatic t_uword urom(input logic [UPC_W-1:0] pc);
        case (pc)
            4'd0:  urom = mk(OP_MUL, SRC_STEP_R, SRC_COL, DST_T, 1'b0, 1'b0, 1'b0, '0);
            4'd1:  urom = mk(OP_ADD, SRC_ORG_R, SRC_T, DST_CR, 1'b0, 1'b0, 1'b0, '0);
            4'd2:  urom = mk(OP_MUL, SRC_STEP_I, SRC_ROW, DST_T, 1'b0, 1'b0, 1'b0, '0);
            4'd3:  urom = mk(OP_ADD, SRC_ORG_I, SRC_T, DST_CI, 1'b0, 1'b0, 1'b0, '0);
            4'd4:  urom = mk(OP_CLR, SRC_ZR, SRC_ZR, DST_NONE, 1'b0, 1'b0, 1'b0, '0);
            4'd5:  urom = mk(OP_TLIM, SRC_ZR, SRC_ZR, DST_NONE, 1'b0, 1'b0, 1'b0, UPC_DONE);
            4'd6:  urom = mk(OP_MUL, SRC_ZR, SRC_ZR, DST_SR, 1'b1, 1'b0, 1'b0, '0);
            4'd7:  urom = mk(OP_MUL, SRC_ZI, SRC_ZI, DST_SI, 1'b1, 1'b0, 1'b0, '0);
            4'd8:  urom = mk(OP_ADD, SRC_SR, SRC_SI, DST_T, 1'b0, 1'b0, 1'b0, '0);
            4'd9:  urom = mk(OP_TESC, SRC_ZR, SRC_ZR, DST_NONE, 1'b0, 1'b0, 1'b0, UPC_DONE);
            4'd10: urom = mk(OP_MUL, SRC_ZR, SRC_ZI, DST_CROSS, 1'b1, 1'b0, 1'b0, '0);
            4'd11: urom = mk(OP_SUB, SRC_SR, SRC_SI, DST_T, 1'b0, 1'b0, 1'b0, '0);
            4'd12: urom = mk(OP_ADD, SRC_T, SRC_CR, DST_ZR, 1'b0, 1'b0, 1'b0, '0);
            4'd13: urom = mk(OP_ADD, SRC_CROSS, SRC_CROSS, DST_T, 1'b0, 1'b0, 1'b0, '0);
            4'd14: urom = mk(OP_ADD, SRC_T, SRC_CI, DST_ZI, 1'b0, 1'b1, 1'b1, UPC_LOOP);
            default: urom = mk(OP_FINISH, SRC_ZR, SRC_ZR, DST_NONE, 1'b0, 1'b0, 1'b0, '0);
        endcase
    endfunction

    logic                          r_run, n_run;
    logic [UPC_W-1:0]              r_upc, n_upc;
    logic [2:0]                    r_pp, n_pp;
    logic [INDEX_BITS-1:0]         r_col, r_row;
    logic signed [COORD_BITS-1:0]  r_zr, r_zi, r_sr, r_si, r_cross, r_t, r_cr, r_ci;
    logic [ITER_BITS-1:0]          r_ct;
    logic [MW-1:0]                 r_mag_a, r_mag_b;
    logic                          r_neg;
    logic [ACC_W-1:0]              r_acc;
    logic                          r_done, r_escaped;
    logic [ITER_BITS-1:0]          r_count;

    t_uword                        uw;
    logic signed [COORD_BITS-1:0]  op_a, op_b;
    logic [COORD_BITS-1:0]         mag_a, mag_b;
    logic [1:0]                    k;
    logic [HALF-1:0]               pa, pb;
    logic [MW-1:0]                 prod;
    logic [ACC_W-1:0]              part;
    logic [ACC_W-1:0]              shifted;
    logic                          ovf;
    logic signed [COORD_BITS-1:0]  mul_res;
    logic signed [COORD_BITS:0]    sum;
    logic signed [COORD_BITS-1:0]  add_res, res;
    logic                          exec;

    assign uw = urom(r_upc);

    always_comb begin
        case (uw.a)
            SRC_ZR:     op_a = r_zr;
            SRC_ZI:     op_a = r_zi;
            SRC_SR:     op_a = r_sr;
            SRC_SI:     op_a = r_si;
            SRC_CROSS:  op_a = r_cross;
            SRC_T:      op_a = r_t;
            SRC_CR:     op_a = r_cr;
            SRC_CI:     op_a = r_ci;
            SRC_ORG_R:  op_a = i_origin_real;
            SRC_ORG_I:  op_a = i_origin_imag;
            SRC_STEP_R: op_a = i_step_real;
            SRC_STEP_I: op_a = i_step_imag;
            SRC_COL:    op_a = COORD_BITS'(r_col);
            SRC_ROW:    op_a = COORD_BITS'(r_row);
            default:    op_a = '0;
        endcase
        case (uw.b)
            SRC_ZR:     op_b = r_zr;
            SRC_ZI:     op_b = r_zi;
            SRC_SR:     op_b = r_sr;
            SRC_SI:     op_b = r_si;
            SRC_CROSS:  op_b = r_cross;
            SRC_T:      op_b = r_t;
            SRC_CR:     op_b = r_cr;
            SRC_CI:     op_b = r_ci;
            SRC_ORG_R:  op_b = i_origin_real;
            SRC_ORG_I:  op_b = i_origin_imag;
            SRC_STEP_R: op_b = i_step_real;
            SRC_STEP_I: op_b = i_step_imag;
            SRC_COL:    op_b = COORD_BITS'(r_col);
            SRC_ROW:    op_b = COORD_BITS'(r_row);
            default:    op_b = '0;
        endcase
    end

    // Multiplier: magnitudes are latched first, then four half-width
    // partial products are summed, then the product is scaled and clamped.
    assign mag_a = op_a[COORD_BITS-1] ? (~op_a + 1'b1) : op_a;
    assign mag_b = op_b[COORD_BITS-1] ? (~op_b + 1'b1) : op_b;
    assign k     = 2'(r_pp - 3'd1);
    assign pa    = k[0] ? r_mag_a[MW-1:HALF] : r_mag_a[HALF-1:0];
    assign pb    = k[1] ? r_mag_b[MW-1:HALF] : r_mag_b[HALF-1:0];
    assign prod  = pa * pb;

    always_comb begin
        case ({1'b0, k[0]} + {1'b0, k[1]})
            2'd0:    part = ACC_W'(prod);
            2'd1:    part = ACC_W'(prod) << HALF;
            default: part = ACC_W'(prod) << (2 * HALF);
        endcase
    end

    assign shifted = uw.frac ? (r_acc >> FRAC) : r_acc;
    assign ovf     = |shifted[ACC_W-1:COORD_BITS-1];

    always_comb begin
        if (r_neg) begin
            mul_res = ovf ? MINV : -$signed(shifted[COORD_BITS-1:0]);
        end else begin
            mul_res = ovf ? MAXV : $signed(shifted[COORD_BITS-1:0]);
        end
    end

    // Saturating add and subtract.
    always_comb begin
        if (uw.op == OP_SUB) begin
            sum = {op_a[COORD_BITS-1], op_a} - {op_b[COORD_BITS-1], op_b};
        end else begin
            sum = {op_a[COORD_BITS-1], op_a} + {op_b[COORD_BITS-1], op_b};
        end
        if (sum[COORD_BITS] != sum[COORD_BITS-1]) begin
            add_res = sum[COORD_BITS] ? MINV : MAXV;
        end else begin
            add_res = sum[COORD_BITS-1:0];
        end
    end

    assign res  = (uw.op == OP_MUL) ? mul_res : add_res;
    assign exec = r_run && ((uw.op != OP_MUL) || (r_pp == PP_LAST));

    // Sequencer next state.
    always_comb begin
        n_run = r_run;
        n_upc = r_upc;
        n_pp  = r_pp;
        if (r_run) begin
            if ((uw.op == OP_MUL) && (r_pp != PP_LAST)) begin
                n_pp = r_pp + 3'd1;
            end else begin
                n_pp  = '0;
                n_upc = r_upc + 1'b1;
                case (uw.op)
                    OP_TLIM: begin
                        if (r_ct >= i_max_iterations) n_upc = uw.target;
                    end
                    OP_TESC: begin
                        if (r_t >= FOUR) n_upc = uw.target;
                    end
                    OP_FINISH: begin
                        n_run = 1'b0;
                    end
                    default: begin
                        if (uw.jump) n_upc = uw.target;
                    end
                endcase
            end
        end
        if (i_start) begin
            n_run = 1'b1;
            n_upc = '0;
            n_pp  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_upc  <= '0;
            r_pp   <= '0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_upc  <= n_upc;
            r_pp   <= n_pp;
            r_done <= exec && (uw.op == OP_FINISH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_col <= i_col;
            r_row <= i_row;
        end
        if (r_run && (uw.op == OP_MUL)) begin
            if (r_pp == 3'd0) begin
                r_mag_a <= MW'(mag_a);
                r_mag_b <= MW'(mag_b);
                r_neg   <= op_a[COORD_BITS-1] ^ op_b[COORD_BITS-1];
                r_acc   <= '0;
            end else if (r_pp != PP_LAST) begin
                r_acc <= r_acc + part;
            end
        end
        if (exec) begin
            case (uw.dst)
                DST_T:     r_t     <= res;
                DST_CR:    r_cr    <= res;
                DST_CI:    r_ci    <= res;
                DST_ZR:    r_zr    <= res;
                DST_ZI:    r_zi    <= res;
                DST_SR:    r_sr    <= res;
                DST_SI:    r_si    <= res;
                DST_CROSS: r_cross <= res;
                default: begin
                end
            endcase
            if (uw.op == OP_CLR) begin
                r_zr <= '0;
                r_zi <= '0;
                r_ct <= '0;
            end
            if (uw.inc) r_ct <= r_ct + 1'b1;
            if (uw.op == OP_FINISH) begin
                r_count   <= r_ct;
                r_escaped <= r_ct < i_max_iterations;
            end
        end
    end

    assign o_busy           = r_run;
    assign o_status.done    = r_done;
    assign o_status.escaped = r_escaped;
    assign o_status.count   = r_count;

endmodule

// ----- rtl/mandelbrot_escape_time_pixel.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel shader
// Maps a pixel index pair to a point of the plane, iterates z = z*z + c and
// returns a grey level, the iteration count and an escape flag.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken at a rising edge where start is high and busy is low; the
// pixel column and row are sampled on that edge. Busy stays high until the
// cycle that carries the result beat. The result sits on o_shade,
// o_iteration_count and o_escaped for exactly one cycle, marked by o_done;
// the receiver cannot stall, so no result is ever held back.
// An item runs through pixel mapping, then the iteration loop, and leaves it
// at the iteration limit or on escape; the default limit is 256. A new item
// can be taken on the edge that ends the result cycle. The single shared
// multiplier works through each product in order (it latches magnitudes, sums
// four half-width partial products, then scales and clamps), and each
// iteration uses three products.
// The configuration channel (i_cfg_valid / o_cfg_ready) is always ready; it
// must only be written while busy is low. Unknown indexes are dropped.
// Reset loads the default view and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
    parameter int COORD_BITS = met_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = met_pkg::INDEX_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [INDEX_BITS-1:0]            i_pixel_col,
    input  logic [INDEX_BITS-1:0]            i_pixel_row,
    output logic                             o_done,
    output logic [met_pkg::SHADE_BITS-1:0]   o_shade,
    output logic [met_pkg::ITER_BITS-1:0]    o_iteration_count,
    output logic                             o_escaped,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [met_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [COORD_BITS-1:0]            i_cfg_data
);
    import met_pkg::*;

    localparam int FRAC = COORD_BITS - 4;
    localparam int PW   = ITER_BITS + SCALE_BITS;

    // Default view: origin (-2.25, -2.0), step 2^-8 per pixel.
    localparam logic [COORD_BITS-1:0] NINE_Q   = COORD_BITS'(9) << (FRAC - 2);
    localparam logic [COORD_BITS-1:0] TWO_Q    = COORD_BITS'(2) << FRAC;
    localparam logic [COORD_BITS-1:0] RST_OR   = COORD_BITS'(0) - NINE_Q;
    localparam logic [COORD_BITS-1:0] RST_OI   = COORD_BITS'(0) - TWO_Q;
    localparam logic [COORD_BITS-1:0] RST_STEP = COORD_BITS'(1) << (FRAC - 8);
    localparam logic [ITER_BITS-1:0]  RST_MAX  = ITER_BITS'(256);
    localparam logic [SCALE_BITS-1:0] RST_SCL  = SCALE_BITS'(256);

    logic signed [COORD_BITS-1:0] r_origin_real, r_origin_imag;
    logic signed [COORD_BITS-1:0] r_step_real, r_step_imag;
    logic [ITER_BITS-1:0]         r_max_iterations;
    logic [SCALE_BITS-1:0]        r_intensity_scale;
    logic                         r_done;
    logic [SHADE_BITS-1:0]        r_shade;
    logic [ITER_BITS-1:0]         r_count;
    logic                         r_escaped;

    logic                         core_busy;
    t_status                      status;
    logic                         accept;
    logic [PW-1:0]                scaled;
    logic [SHADE_BITS-1:0]        n_shade;

    assign o_cfg_ready = 1'b1;

    // Configuration registers. The iteration limit and the scale take the
    // low bits of the data word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_real     <= RST_OR;
            r_origin_imag     <= RST_OI;
            r_step_real       <= RST_STEP;
            r_step_imag       <= RST_STEP;
            r_max_iterations  <= RST_MAX;
            r_intensity_scale <= RST_SCL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ORIGIN_REAL:     r_origin_real     <= i_cfg_data;
                CFG_ORIGIN_IMAG:     r_origin_imag     <= i_cfg_data;
                CFG_STEP_REAL:       r_step_real       <= i_cfg_data;
                CFG_STEP_IMAG:       r_step_imag       <= i_cfg_data;
                CFG_MAX_ITERATIONS:  r_max_iterations  <= i_cfg_data[ITER_BITS-1:0];
                CFG_INTENSITY_SCALE: r_intensity_scale <= i_cfg_data[SCALE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Busy covers the cycle in which the core hands its result over, so a
    // new item never starts before the previous beat is out.
    assign busy   = core_busy || status.done;
    assign accept = start && !busy;

    met_core #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (accept),
        .i_col            (i_pixel_col),
        .i_row            (i_pixel_row),
        .i_origin_real    (r_origin_real),
        .i_origin_imag    (r_origin_imag),
        .i_step_real      (r_step_real),
        .i_step_imag      (r_step_imag),
        .i_max_iterations (r_max_iterations),
        .o_busy           (core_busy),
        .o_status         (status)
    );

    // Shade: count times the Q8.8 scale, integer part, clamped to white.
    // Points that stay bounded are always white.
    assign scaled = status.count * r_intensity_scale;

    always_comb begin
        if (!status.escaped || (|scaled[PW-1:SCALE_FRAC+SHADE_BITS])) begin
            n_shade = {SHADE_BITS{1'b1}};
        end else begin
            n_shade = scaled[SCALE_FRAC+SHADE_BITS-1:SCALE_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= status.done;
        end
        if (status.done) begin
            r_shade   <= n_shade;
            r_count   <= status.count;
            r_escaped <= status.escaped;
        end
    end

    assign o_done            = r_done;
    assign o_shade           = r_shade;
    assign o_iteration_count = r_count;
    assign o_escaped         = r_escaped;

    // Two result beats can never come back to back.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // An accepted item keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after taking an item");

    // A result only appears after the block was busy with an item.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result beat without an item in flight");

    // A point that did not escape is shaded white.
    a_inside_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_escaped) |-> (o_shade == {SHADE_BITS{1'b1}}))
        else $error("bounded point not shaded white");

endmodule
